### src/level_crossing_peak_trough_detector_macros.svh
// Assertion macros shared by the level-crossing detector RTL.
`ifndef LEVEL_CROSSING_PEAK_TROUGH_DETECTOR_MACROS_SVH
`define LEVEL_CROSSING_PEAK_TROUGH_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lcpt_pkg.sv
// Types and constants for the level-crossing peak and trough detector.
package lcpt_pkg;

   // Input kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_END    = 1'b1;

   // Result kinds.
   localparam logic [1:0] RESULT_PEAK    = 2'd0;
   localparam logic [1:0] RESULT_TROUGH  = 2'd1;
   localparam logic [1:0] RESULT_SUMMARY = 2'd2;

   // Result queue: holds the two results of one end transaction plus slack.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        kind;
      logic [31:0] sample_value;
      logic [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] extreme_value;
      logic [31:0] extreme_time;
      logic [15:0] pair_index;
      logic        last;
   } rsp_type;

endpackage

### src/level_crossing_peak_trough_detector.sv
// Level-crossing peak and trough detector: top level with run tracking and result queue.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  lcpt_pkg::req_type (kind, value, time)
//   rsp_      out        rsp_valid/rsp_stall  lcpt_pkg::rsp_type (kind, extreme, index, last)
//   csr_      in         csr_valid/csr_ready  32-bit level
//
// One transaction is taken per cycle while req_stall is low; its state update and results
// are formed in the same cycle and written to the run registers and a four-entry result
// queue. A result is offered on rsp_ from the cycle after its transaction was accepted,
// once earlier results are popped. req_stall rises when fewer than two entries are free,
// so a stalled result side holds the input back before the queue fills.
// Reset is synchronous and active high; it clears the run state, the queue and the level.
`include "level_crossing_peak_trough_detector_macros.svh"

module level_crossing_peak_trough_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcpt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   localparam int unsigned AW = lcpt_pkg::QUEUE_AW;
   localparam int unsigned CW = lcpt_pkg::QUEUE_CW;

   // Threshold register.
   logic [31:0] level_ff;

   // Run state.
   logic        started_ff,     started_in;
   logic        positive_ff,    positive_in;
   logic [31:0] extreme_ff,     extreme_in;
   logic [31:0] ext_time_ff,    ext_time_in;
   logic        second_ff,      second_in;
   logic [15:0] pair_count_ff,  pair_count_in;

   // Result queue.
   lcpt_pkg::rsp_type queue_ff [lcpt_pkg::QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;

   logic              req_accept;
   logic              rsp_pop;
   logic              sample_pos;
   logic              take_extreme;
   logic [15:0]       pair_inc;
   logic [1:0]        push_num;
   lcpt_pkg::rsp_type slot0;
   lcpt_pkg::rsp_type slot1;
   lcpt_pkg::rsp_type excursion;

   // The input waits whenever the queue could not absorb the two results of an end transaction.
   assign req_stall  = (count_ff > CW'(lcpt_pkg::QUEUE_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = queue_ff[rd_ptr_ff];
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;

   assign sample_pos   = (req_data.sample_value > level_ff);
   assign take_extreme = positive_ff ? (req_data.sample_value >= extreme_ff)
                                     : (req_data.sample_value <= extreme_ff);
   // The pair count saturates at its maximum.
   assign pair_inc     = (pair_count_ff == '1) ? pair_count_ff : pair_count_ff + 16'd1;

   // The excursion currently held, as it would be reported if it closed now.
   always_comb begin
      excursion.result_kind   = positive_ff ? lcpt_pkg::RESULT_PEAK : lcpt_pkg::RESULT_TROUGH;
      excursion.extreme_value = extreme_ff;
      excursion.extreme_time  = ext_time_ff;
      excursion.pair_index    = pair_count_ff;
      excursion.last          = 1'b1;
   end

   always_comb begin
      started_in    = started_ff;
      positive_in   = positive_ff;
      extreme_in    = extreme_ff;
      ext_time_in   = ext_time_ff;
      second_in     = second_ff;
      pair_count_in = pair_count_ff;
      push_num      = 2'd0;
      slot0         = excursion;
      slot1         = excursion;

      if (req_accept) begin
         case (req_data.kind)
            lcpt_pkg::KIND_END: begin
               slot0.result_kind   = lcpt_pkg::RESULT_SUMMARY;
               slot0.extreme_value = '0;
               slot0.extreme_time  = '0;
               slot0.pair_index    = pair_count_ff;
               slot0.last          = 1'b1;
               push_num            = 2'd1;
               // A pending second excursion completes its pair before the summary.
               if (started_ff && second_ff) begin
                  slot0               = excursion;
                  slot0.last          = 1'b0;
                  slot1.result_kind   = lcpt_pkg::RESULT_SUMMARY;
                  slot1.extreme_value = '0;
                  slot1.extreme_time  = '0;
                  slot1.pair_index    = pair_inc;
                  slot1.last          = 1'b1;
                  push_num            = 2'd2;
               end
               started_in    = 1'b0;
               positive_in   = 1'b0;
               extreme_in    = '0;
               ext_time_in   = '0;
               second_in     = 1'b0;
               pair_count_in = '0;
            end
            default: begin
               if (started_ff && (sample_pos == positive_ff)) begin
                  // Same sign: track the extreme, a tie moves the time on.
                  if (take_extreme) begin
                     extreme_in  = req_data.sample_value;
                     ext_time_in = req_data.sample_time;
                  end
               end else begin
                  if (started_ff) begin
                     // Sign change closes the running excursion.
                     push_num = 2'd1;
                     if (second_ff) begin
                        pair_count_in = pair_inc;
                     end
                     second_in = !second_ff;
                  end
                  started_in  = 1'b1;
                  positive_in = sample_pos;
                  extreme_in  = req_data.sample_value;
                  ext_time_in = req_data.sample_time;
               end
            end
         endcase
      end

      wr_ptr_in = wr_ptr_ff + AW'(push_num);
      rd_ptr_in = rd_ptr_ff + AW'(rsp_pop);
      count_in  = count_ff + CW'(push_num) - CW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         started_ff    <= 1'b0;
         positive_ff   <= 1'b0;
         extreme_ff    <= '0;
         ext_time_ff   <= '0;
         second_ff     <= 1'b0;
         pair_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            level_ff <= csr_data;
         end
         started_ff    <= started_in;
         positive_ff   <= positive_in;
         extreme_ff    <= extreme_in;
         ext_time_ff   <= ext_time_in;
         second_ff     <= second_in;
         pair_count_ff <= pair_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Queue storage carries no reset; only the pointers and count say what is valid.
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + AW'(1)] <= slot1;
      end
   end

   `LCPT_ASSERT_NOW(a_room_on_accept, clock, reset, req_accept,
      count_ff <= CW'(lcpt_pkg::QUEUE_DEPTH - 2), "transaction accepted without room for two results")
   `LCPT_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      count_ff <= CW'(lcpt_pkg::QUEUE_DEPTH), "result queue count out of range")
   `LCPT_ASSERT_NOW(a_pair_needs_run, clock, reset, !started_ff,
      !second_ff, "second excursion flagged without a run in progress")
   `LCPT_ASSERT_NOW(a_first_sample_silent, clock, reset,
      req_accept && (req_data.kind == lcpt_pkg::KIND_SAMPLE) && !started_ff,
      push_num == 2'd0, "first sample of a series produced a result")
   `LCPT_ASSERT_NEXT(a_end_clears, clock, reset,
      req_accept && (req_data.kind == lcpt_pkg::KIND_END),
      !started_ff && !second_ff && (pair_count_ff == '0), "end transaction left run state behind")

endmodule
